### rtl/core/thdps_pkg.sv
`default_nettype none
package thdps_pkg;

	localparam int DELAY_DEPTH_DEF = 4096;
	localparam int GAIN_SIZE_DEF   = 1024;

	localparam int SAMPLE_W   = 24;
	localparam int DELAY_W    = 20;
	localparam int PHASE_W    = 32;
	localparam int STEPS_W    = 16;
	localparam int LEVEL_W    = 17;
	localparam int FRAC_W     = 8;
	localparam int TAP_W      = 29;   // interpolated tap, unsaturated
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int QUEUE_DEPTH = 2;   // power of two

	localparam logic [LEVEL_W-1:0] UNITY = 17'd65536;
	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	localparam logic signed [TAP_W-1:0] SAT_HI = TAP_W'(8388607);
	localparam logic signed [TAP_W-1:0] SAT_LO = TAP_W'(-8388608);

	localparam logic [CFG_IDX_W-1:0] REG_FLOOR_DELAY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SWEEP_RANGE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_UP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SWEEP_ON    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEPS  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DELAY   = 3'd6;

	typedef struct packed {
		logic [DELAY_W-1:0] floor_delay;
		logic [DELAY_W-1:0] sweep_range;
		logic [PHASE_W-1:0] phase_increment;
		logic               pitch_up;
		logic [STEPS_W-1:0] ramp_steps;
		logic [DELAY_W-1:0] min_delay;
	} cfg_t;

	// write of the engagement target
	typedef struct packed {
		logic set;
		logic target;
	} eng_cmd_t;

	// cos^2 gain in Q.16 for an angle x in Q2.30 (elaboration only)
	function automatic logic [LEVEL_W-1:0] gain_from_x(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sq;
		logic [63:0] g;
		logic signed [63:0] sum;
		x2 = (x * x) >> 30;
		term = 64'd1 << 30;
		sum = signed'(term);
		for (int n = 1; n <= 8; n++) begin
			term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
			if (n % 2 == 1)
				sum = sum - signed'(term);
			else
				sum = sum + signed'(term);
		end
		sq = unsigned'(sum * sum);
		g = (sq + (64'd1 << 43)) >> 44;
		return (g > 64'd65536) ? UNITY : g[LEVEL_W-1:0];
	endfunction

endpackage
`default_nettype wire

### rtl/core/thdps_front.sv
`default_nettype none
module thdps_front
	import thdps_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                enable,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [SAMPLE_W-1:0] sample_in,
	output logic                     q_valid,
	output logic [SAMPLE_W-1:0]      q_sample,
	input  wire logic                q_pop
);
	localparam int QAW = $clog2(QUEUE_DEPTH);

	logic [SAMPLE_W-1:0] buf_q [QUEUE_DEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QAW:0]   cnt_q;
	logic push, pop;

	// items are held until the memory clearing pass is over
	assign in_ready = enable && (cnt_q != (QAW+1)'(QUEUE_DEPTH));
	assign q_valid  = (cnt_q != '0);
	assign q_sample = buf_q[rd_q];
	assign push = in_valid && in_ready;
	assign pop  = q_pop && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			buf_q[wr_q] <= sample_in;
	end

endmodule
`default_nettype wire

### rtl/core/thdps_ramp.sv
`default_nettype none
module thdps_ramp
	import thdps_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire eng_cmd_t           cmd,
	input  wire logic [STEPS_W-1:0] ramp_steps,
	input  wire logic               start,
	output logic [LEVEL_W-1:0]      level,
	output logic                    done
);
	localparam int CNT_W = $clog2(LEVEL_W);

	logic                 target_q;
	logic [LEVEL_W-1:0]   level_q;
	logic [STEPS_W-1:0]   rem_q;
	logic                 busy_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [STEPS_W-1:0]   part_q;
	logic [LEVEL_W-1:0]   dvd_q, quo_q;
	logic                 neg_q;

	logic signed [LEVEL_W:0] diff;
	logic [LEVEL_W-1:0] mag, quo_last, tgt_level;
	logic [STEPS_W:0]   trial;
	logic               fits;

	assign tgt_level = target_q ? UNITY : '0;
	assign diff  = $signed({1'b0, tgt_level}) - $signed({1'b0, level_q});
	assign mag   = diff[LEVEL_W] ? LEVEL_W'(-diff) : LEVEL_W'(diff);
	// restoring division, one quotient bit per cycle unless a sweep_on write intervenes
	assign trial = {part_q, dvd_q[LEVEL_W-1]};
	assign fits  = (trial >= {1'b0, rem_q});
	assign quo_last = {quo_q[LEVEL_W-2:0], fits};

	assign level = level_q;
	assign done  = !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= 1'b0;
			level_q  <= '0;
			rem_q    <= '0;
			busy_q   <= 1'b0;
			cnt_q    <= '0;
			neg_q    <= 1'b0;
			part_q   <= '0;
			dvd_q    <= '0;
			quo_q    <= '0;
		end else if (cmd.set && (cmd.target != target_q)) begin
			target_q <= cmd.target;
			if (ramp_steps == '0) begin
				level_q <= cmd.target ? UNITY : '0;
				rem_q   <= '0;
			end else begin
				rem_q <= ramp_steps;
			end
		end else if (start && (rem_q != '0)) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			part_q <= '0;
			dvd_q  <= mag;
			quo_q  <= '0;
			neg_q  <= diff[LEVEL_W];
		end else if (busy_q) begin
			part_q <= fits ? STEPS_W'(trial - {1'b0, rem_q}) : trial[STEPS_W-1:0];
			dvd_q  <= {dvd_q[LEVEL_W-2:0], 1'b0};
			quo_q  <= quo_last;
			cnt_q  <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(LEVEL_W - 1)) begin
				busy_q  <= 1'b0;
				level_q <= neg_q ? (level_q - quo_last) : (level_q + quo_last);
				rem_q   <= rem_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/core/thdps_cubic.sv
`default_nettype none
module thdps_cubic
	import thdps_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_vld,
	input  wire logic signed [SAMPLE_W-1:0] p0,
	input  wire logic signed [SAMPLE_W-1:0] p1,
	input  wire logic signed [SAMPLE_W-1:0] p2,
	input  wire logic signed [SAMPLE_W-1:0] p3,
	input  wire logic [FRAC_W-1:0]          frac,
	input  wire logic [1:0]                 in_tag,
	output logic                            out_vld,
	output logic [1:0]                      out_tag,
	output logic signed [TAP_W-1:0]         result
);
	localparam int AW_  = SAMPLE_W + 1;
	localparam int BW   = SAMPLE_W + 4;
	localparam int CW   = SAMPLE_W + 3;
	localparam int F2W  = 2 * FRAC_W;
	localparam int AFW  = AW_ + FRAC_W + 1;
	localparam int BFW  = BW + F2W + 1;
	localparam int CFW  = CW + FRAC_W + 1;
	localparam int CF3W = CFW + F2W + 1;
	localparam int SW   = TAP_W + 25;
	localparam logic signed [SW-1:0] RND = SW'(2**24);

	logic              vld_s1, vld_s2, vld_s3;
	logic [1:0]        tag_s1, tag_s2, tag_s3;
	logic signed [AW_-1:0] a_s1;
	logic signed [BW-1:0]  b_s1;
	logic signed [CW-1:0]  c_s1;
	logic signed [SAMPLE_W-1:0] p1_s1, p1_s2;
	logic [FRAC_W-1:0] f_s1;
	logic [F2W-1:0]    f2_s1, f2_s2;
	logic signed [AFW-1:0]  af_s2;
	logic signed [BFW-1:0]  bf2_s2;
	logic signed [CFW-1:0]  cf_s2;
	logic signed [CF3W-1:0] cf3_s3;
	logic signed [SW-1:0]   t_s3, sum;

	assign sum = t_s3 + SW'(cf3_s3) + RND;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			out_vld <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		// polynomial coefficients
		tag_s1 <= in_tag;
		a_s1   <= AW_'(p2) - AW_'(p0);
		b_s1   <= (BW'(p0) <<< 1) - (BW'(p1) <<< 2) - BW'(p1) + (BW'(p2) <<< 2) - BW'(p3);
		c_s1   <= CW'(p3) - CW'(p0) + (CW'(p1) <<< 1) + CW'(p1)
			- (CW'(p2) <<< 1) - CW'(p2);
		p1_s1  <= p1;
		f_s1   <= frac;
		f2_s1  <= F2W'(frac) * F2W'(frac);
		// first products
		tag_s2 <= tag_s1;
		af_s2  <= a_s1 * $signed({1'b0, f_s1});
		bf2_s2 <= b_s1 * $signed({1'b0, f2_s1});
		cf_s2  <= c_s1 * $signed({1'b0, f_s1});
		p1_s2  <= p1_s1;
		f2_s2  <= f2_s1;
		// cubic term, partial sum
		tag_s3 <= tag_s2;
		cf3_s3 <= cf_s2 * $signed({1'b0, f2_s2});
		t_s3   <= (SW'(p1_s2) <<< 25) + (SW'(af_s2) <<< 16) + (SW'(bf2_s2) <<< 8);
		// round half up from Q.25
		out_tag <= tag_s3;
		result  <= sum[SW-1:25];
	end

endmodule
`default_nettype wire

### rtl/core/thdps_back.sv
`default_nettype none
module thdps_back
	import thdps_pkg::*;
#(
	parameter int DELAY_DEPTH     = DELAY_DEPTH_DEF,
	parameter int GAIN_TABLE_SIZE = GAIN_SIZE_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cfg_t                cfg,
	input  wire eng_cmd_t            eng_cmd,
	output logic                     cleared,
	input  wire logic                q_valid,
	input  wire logic [SAMPLE_W-1:0] q_sample,
	output logic                     q_pop,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [SAMPLE_W-1:0]      sample_out
);
	localparam int AW     = $clog2(DELAY_DEPTH);
	localparam int DW     = AW + FRAC_W;
	localparam int DSW    = (DW > DELAY_W + 1) ? DW : DELAY_W + 1;
	localparam int GIW    = $clog2(GAIN_TABLE_SIZE);
	localparam int GNW    = GIW + 1;
	localparam int PRODW  = DELAY_W + PHASE_W + 1;
	localparam int NTAPS  = 3;
	localparam int NREADS = 4 * NTAPS;
	localparam int MIXW   = LEVEL_W + 1 + TAP_W;
	localparam logic [DSW-1:0]        DELAY_HI  = DSW'((DELAY_DEPTH - 4) * 256);
	localparam logic [AW-1:0]         LAST_ADDR = AW'(DELAY_DEPTH - 1);
	localparam logic signed [AW+1:0]  DEPTH_S   = (AW+2)'(DELAY_DEPTH);
	localparam logic signed [MIXW:0]  RND16     = (MIXW+1)'(2**15);

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_READ, ST_WAIT,
		ST_MIX_MUL, ST_MIX_SUM, ST_BLEND_MUL, ST_OUT
	} state_t;

	state_t state_q;
	logic [AW-1:0] clr_q, wp_q, wp_n;
	logic [PHASE_W-1:0] phase_q;
	logic [3:0] rd_cnt_q;
	logic [1:0] taps_q;
	logic       rd_vld_s1;
	logic [1:0] rd_tap_s1, rd_j_s1;

	logic [SAMPLE_W-1:0] mem [DELAY_DEPTH];
	logic                mem_we;
	logic [AW-1:0]       mem_wa;
	logic [SAMPLE_W-1:0] mem_wd;
	logic [SAMPLE_W-1:0] rdata_s1;

	logic [PRODW-1:0] prod_q;
	logic [DW-1:0]    cdel_q [NTAPS];
	logic signed [SAMPLE_W-1:0] samp_q [3];
	logic signed [TAP_W-1:0]    tapres_q [NTAPS];
	logic signed [MIXW-1:0]     pa_q, pb_q, b1_q, b2_q;
	logic signed [TAP_W-1:0]    sw_q;

	logic [LEVEL_W-1:0] gain_rom [GAIN_TABLE_SIZE];
	logic [PHASE_W+GNW-1:0] gi_prod;
	logic [GIW-1:0]     gi_s1;
	logic [LEVEL_W-1:0] gain_s2;

	logic [1:0] rd_tap, rd_j;
	logic [DW-1:0] rd_del;
	logic signed [AW+1:0] rd_dist, rd_diff, rd_wrap;
	logic [AW-1:0] rd_addr;

	logic                 start, cb_vld, cb_out_vld;
	logic [1:0]           cb_out_tag;
	logic signed [TAP_W-1:0] cb_res;
	logic [LEVEL_W-1:0]   level;
	logic                 ramp_done;
	logic                 out_free;

	logic signed [MIXW:0]    blend_sum;
	logic signed [TAP_W-1:0] res;

	// cos^2 gain table, worked out at elaboration
	for (genvar k = 0; k < GAIN_TABLE_SIZE; k++) begin : g_gain
		localparam int KR = (2 * k <= GAIN_TABLE_SIZE) ? k : GAIN_TABLE_SIZE - k;
		localparam logic [63:0] GX = (PI_Q30 * KR) / GAIN_TABLE_SIZE;
		assign gain_rom[k] = gain_from_x(GX);
	end

	function automatic logic [PHASE_W:0] sweep_pos(input logic [PHASE_W-1:0] p,
			input logic up);
		return up ? ({1'b1, {PHASE_W{1'b0}}} - {1'b0, p}) : {1'b0, p};
	endfunction

	function automatic logic [DW-1:0] clamp_delay(input logic [DSW-1:0] raw,
			input logic [DELAY_W-1:0] lo);
		logic [DSW-1:0] v;
		v = (raw < DSW'(lo)) ? DSW'(lo) : raw;
		if (v > DELAY_HI)
			v = DELAY_HI;
		return v[DW-1:0];
	endfunction

	function automatic logic [SAMPLE_W-1:0] saturate(input logic signed [TAP_W-1:0] v);
		if (v > SAT_HI)
			return SAT_HI[SAMPLE_W-1:0];
		else if (v < SAT_LO)
			return SAT_LO[SAMPLE_W-1:0];
		else
			return v[SAMPLE_W-1:0];
	endfunction

	assign wp_n    = (wp_q == LAST_ADDR) ? '0 : wp_q + 1'b1;
	assign start   = (state_q == ST_IDLE) && q_valid;
	assign q_pop   = start;
	assign cleared = (state_q != ST_CLEAR);
	assign out_free = !out_valid || out_ready;

	assign gi_prod = (PHASE_W+GNW)'(phase_q) * (PHASE_W+GNW)'(GAIN_TABLE_SIZE);

	// read address: write pointer minus tap distance, wrapped into the store
	assign rd_tap  = rd_cnt_q[3:2];
	assign rd_j    = rd_cnt_q[1:0];
	assign rd_del  = cdel_q[rd_tap];
	always_comb begin
		rd_dist = $signed({2'b00, rd_del[DW-1:FRAC_W]}) + $signed({{AW{1'b0}}, rd_j})
			- $signed((AW+2)'(1));
		rd_diff = $signed({2'b00, wp_q}) - rd_dist;
		if (rd_diff < 0)
			rd_wrap = rd_diff + DEPTH_S;
		else if (rd_diff >= DEPTH_S)
			rd_wrap = rd_diff - DEPTH_S;
		else
			rd_wrap = rd_diff;
		rd_addr = rd_wrap[AW-1:0];
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = wp_n;
		mem_wd = q_sample;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = '0;
		end else if (start) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rdata_s1 <= mem[rd_addr];
	end

	assign cb_vld = rd_vld_s1 && (rd_j_s1 == 2'd3);

	thdps_cubic u_cubic (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (cb_vld),
		.p0      (samp_q[0]),
		.p1      (samp_q[1]),
		.p2      (samp_q[2]),
		.p3      ($signed(rdata_s1)),
		.frac    (cdel_q[rd_tap_s1][FRAC_W-1:0]),
		.in_tag  (rd_tap_s1),
		.out_vld (cb_out_vld),
		.out_tag (cb_out_tag),
		.result  (cb_res)
	);

	thdps_ramp u_ramp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (eng_cmd),
		.ramp_steps (cfg.ramp_steps),
		.start      (start),
		.level      (level),
		.done       (ramp_done)
	);

	assign blend_sum = (MIXW+1)'(b1_q) + (MIXW+1)'(b2_q) + RND16;
	always_comb begin
		if (level == '0)
			res = tapres_q[0];
		else if (level >= UNITY)
			res = sw_q;
		else
			res = blend_sum[16 +: TAP_W];
	end

	// datapath
	always_ff @(posedge clk) begin
		gi_s1   <= gi_prod[PHASE_W +: GIW];
		gain_s2 <= gain_rom[gi_s1];
		if (rd_vld_s1 && (rd_j_s1 != 2'd3))
			samp_q[rd_j_s1] <= $signed(rdata_s1);
		if (cb_out_vld)
			tapres_q[cb_out_tag] <= cb_res;
		if (start) begin
			cdel_q[0] <= clamp_delay(DSW'(cfg.floor_delay), cfg.min_delay);
			prod_q <= PRODW'(cfg.sweep_range)
				* PRODW'(sweep_pos(phase_q + {1'b1, {(PHASE_W-1){1'b0}}}, cfg.pitch_up));
		end
		if (state_q == ST_READ && rd_cnt_q == 4'd0) begin
			cdel_q[1] <= clamp_delay(DSW'(cfg.floor_delay) + DSW'(prod_q[PRODW-1:PHASE_W]),
				cfg.min_delay);
			prod_q <= PRODW'(cfg.sweep_range) * PRODW'(sweep_pos(phase_q, cfg.pitch_up));
		end
		if (state_q == ST_READ && rd_cnt_q == 4'd1)
			cdel_q[2] <= clamp_delay(DSW'(cfg.floor_delay) + DSW'(prod_q[PRODW-1:PHASE_W]),
				cfg.min_delay);
		if (state_q == ST_MIX_MUL) begin
			pa_q <= $signed({1'b0, gain_s2}) * tapres_q[1];
			pb_q <= $signed({1'b0, UNITY - gain_s2}) * tapres_q[2];
		end
		if (state_q == ST_MIX_SUM)
			sw_q <= TAP_W'(((MIXW+1)'(pa_q) + (MIXW+1)'(pb_q) + RND16) >>> 16);
		if (state_q == ST_BLEND_MUL) begin
			b1_q <= tapres_q[0] * $signed({1'b0, UNITY - level});
			b2_q <= sw_q * $signed({1'b0, level});
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			wp_q       <= '0;
			phase_q    <= '0;
			rd_cnt_q   <= '0;
			taps_q     <= '0;
			rd_vld_s1  <= 1'b0;
			rd_tap_s1  <= '0;
			rd_j_s1    <= '0;
			out_valid  <= 1'b0;
			sample_out <= '0;
		end else begin
			rd_vld_s1 <= (state_q == ST_READ);
			rd_tap_s1 <= rd_tap;
			rd_j_s1   <= rd_j;
			if (out_valid && out_ready && !(state_q == ST_OUT && out_free))
				out_valid <= 1'b0;
			if (start)
				taps_q <= '0;
			else if (cb_out_vld)
				taps_q <= taps_q + 1'b1;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_ADDR)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (q_valid) begin
						wp_q     <= wp_n;
						rd_cnt_q <= '0;
						state_q  <= ST_READ;
					end
				end
				ST_READ: begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
					if (rd_cnt_q == 4'(NREADS - 1))
						state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (taps_q == 2'(NTAPS) && ramp_done)
						state_q <= ST_MIX_MUL;
				end
				ST_MIX_MUL:   state_q <= ST_MIX_SUM;
				ST_MIX_SUM:   state_q <= ST_BLEND_MUL;
				ST_BLEND_MUL: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						sample_out <= saturate(res);
						out_valid  <= 1'b1;
						if (level != '0)
							phase_q <= phase_q + cfg.phase_increment;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/core/two_head_delay_pitch_shifter.sv
// Two-head delay-line pitch shifter.
// Input channel in_valid/in_ready/sample_in takes one Q1.23 audio item; output
// channel out_valid/out_ready/sample_out returns exactly one Q1.23 item for it,
// saturated. Configuration writes arrive on cfg_valid/cfg_ready with cfg_index
// and cfg_data; cfg_ready is always high, and writes are meant to land only
// while the block is idle. Index 4 (sweep_on) sets the engagement ramp's target.
// Each item: sample written to the delay store, twelve reads for the static
// and two swept taps, a four-stage cubic interpolator, crossfade and blend.
// The engine takes an item off the queue, makes twelve serial reads, runs the
// interpolator, then does tap capture, wait, mix, sum, blend and output; it
// takes the next item only after the previous result is registered for output.
// The ramp divider (one quotient bit a cycle unless a sweep_on write intervenes)
// runs alongside. Reset: configuration returns to its reset values and a
// clearing pass zeroes all DELAY_DEPTH words of the delay store (4096 by
// default), during which in_ready stays low. A two-item queue keeps taking
// items while a result waits in the output register; if out_ready stays low
// the engine holds its finished item and the queue fills, then in_ready drops.
`default_nettype none
module two_head_delay_pitch_shifter
	import thdps_pkg::*;
#(
	parameter int DELAY_DEPTH     = DELAY_DEPTH_DEF,
	parameter int GAIN_TABLE_SIZE = GAIN_SIZE_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [SAMPLE_W-1:0]   sample_in,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [SAMPLE_W-1:0]        sample_out,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);
	cfg_t     cfg_q;
	eng_cmd_t eng_cmd;
	logic     cfg_wr;
	logic     cleared;
	logic     q_valid, q_pop;
	logic [SAMPLE_W-1:0] q_sample;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// sweep_on lives with the ramp; only the write event goes down
	assign eng_cmd.set    = cfg_wr && (cfg_index == REG_SWEEP_ON);
	assign eng_cmd.target = cfg_data[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.floor_delay     <= '0;
			cfg_q.sweep_range     <= '0;
			cfg_q.phase_increment <= '0;
			cfg_q.pitch_up        <= 1'b0;
			cfg_q.ramp_steps      <= 16'd1024;
			cfg_q.min_delay       <= 20'd256;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_FLOOR_DELAY: cfg_q.floor_delay     <= cfg_data[DELAY_W-1:0];
				REG_SWEEP_RANGE: cfg_q.sweep_range     <= cfg_data[DELAY_W-1:0];
				REG_PHASE_INC:   cfg_q.phase_increment <= cfg_data[PHASE_W-1:0];
				REG_PITCH_UP:    cfg_q.pitch_up        <= cfg_data[0];
				REG_RAMP_STEPS:  cfg_q.ramp_steps      <= cfg_data[STEPS_W-1:0];
				REG_MIN_DELAY:   cfg_q.min_delay       <= cfg_data[DELAY_W-1:0];
				default: ;   // sweep_on handled by the ramp; unknown index ignored
			endcase
		end
	end

	// front: input queue
	thdps_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.enable    (cleared),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample_in (sample_in),
		.q_valid   (q_valid),
		.q_sample  (q_sample),
		.q_pop     (q_pop)
	);

	// back: delay store, taps, mix, output register
	thdps_back #(
		.DELAY_DEPTH     (DELAY_DEPTH),
		.GAIN_TABLE_SIZE (GAIN_TABLE_SIZE)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.eng_cmd    (eng_cmd),
		.cleared    (cleared),
		.q_valid    (q_valid),
		.q_sample   (q_sample),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out)
	);

endmodule
`default_nettype wire
